// ----- hw/rtl/fptd_pkg.sv -----
`timescale 1ns / 1ps

package fptd_pkg;

  localparam int NUM_OPS   = 36;
  localparam int FPOP1_OPS = 34;
  localparam int OP_W      = 6;
  localparam int REG_W     = 6;

  // Opcode class match on the op and op3 fields
  localparam logic [31:0] OPC_MASK    = 32'hc1f80000;
  localparam logic [31:0] OPC_FPOP1   = 32'h81a00000;
  localparam logic [31:0] OPC_FPOP2   = 32'h81a80000;

  // Result status codes
  localparam logic [1:0] ST_EMULATE     = 2'd0;
  localparam logic [1:0] ST_NOT_OP      = 2'd1;
  localparam logic [1:0] ST_TT_MISMATCH = 2'd2;
  localparam logic [1:0] ST_BAD_REG     = 2'd3;

  // Operand precision codes in the kind table
  localparam logic [1:0] PREC_NONE = 2'd0;
  localparam logic [1:0] PREC_S    = 2'd1;
  localparam logic [1:0] PREC_D    = 2'd2;
  localparam logic [1:0] PREC_Q    = 2'd3;

  localparam logic [3:0] TT_CLEAR   = 4'd0;
  localparam logic [3:0] TT_BAD_REG = 4'd6;

  // State bits
  localparam int FPRS_DL = 0;
  localparam int FPRS_DU = 1;
  localparam int FPRS_EN = 2;
  localparam logic [2:0] FPRS_ENABLE_ONLY = 3'b100;

  localparam logic [8:0] OPF_CODE [NUM_OPS] = '{
    9'h003, 9'h007, 9'h00b, 9'h02b, 9'h043, 9'h047, 9'h04b, 9'h04f, 9'h06e,
    9'h083, 9'h08c, 9'h0c7, 9'h0cb, 9'h0cc, 9'h0cd, 9'h0ce, 9'h0d3,
    9'h029, 9'h02a, 9'h041, 9'h042, 9'h045, 9'h046, 9'h049, 9'h04a, 9'h04d,
    9'h04e, 9'h069, 9'h081, 9'h082, 9'h0c6, 9'h0c9, 9'h0d1, 9'h0d2,
    9'h053, 9'h057
  };

  // [1:0] rs1 precision, [3:2] rs2, [5:4] rd (none = fcc), [11:8] trap type
  localparam logic [11:0] OP_KIND [NUM_OPS] = '{
    12'h33c, 12'h33c, 12'h33c, 12'h33c, 12'h33f, 12'h33f, 12'h33f, 12'h33f,
    12'h33a, 12'h32c, 12'h338, 12'h31c, 12'h32c, 12'h334, 12'h334, 12'h338,
    12'h31c, 12'h214, 12'h228, 12'h215, 12'h22a, 12'h215, 12'h22a, 12'h215,
    12'h22a, 12'h215, 12'h22a, 12'h225, 12'h224, 12'h228, 12'h218, 12'h224,
    12'h214, 12'h218, 12'h30f, 12'h30f
  };

  typedef struct packed {
    logic [31:0] insn_word;
    logic [3:0]  trap_type;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [OP_W-1:0]  op_code;
    logic [REG_W-1:0] src1_index;
    logic             src1_zero;
    logic [REG_W-1:0] src2_index;
    logic             src2_zero;
    logic [REG_W-1:0] dest_index;
    logic             dest_is_fcc;
    logic             clear_lower_half;
    logic             clear_upper_half;
    logic             clear_gsr;
    logic [3:0]       new_trap_type;
  } out_item_t;

  typedef struct packed {
    logic            hit;
    logic [OP_W-1:0] op;
    logic [11:0]     kind;
  } dec_t;

endpackage

// ----- hw/rtl/fptd_decode.sv -----
`timescale 1ns / 1ps

module fptd_decode (
  input  logic [31:0]   insn_word,
  output fptd_pkg::dec_t dec
);

  logic [8:0] opf;
  logic       is_fpop1;
  logic       is_fpop2;

  assign opf      = insn_word[13:5];
  assign is_fpop1 = (insn_word & fptd_pkg::OPC_MASK) == fptd_pkg::OPC_FPOP1;
  assign is_fpop2 = (insn_word & fptd_pkg::OPC_MASK) == fptd_pkg::OPC_FPOP2;

  // Match opf against every table entry of the selected class
  always_comb begin
    dec = '0;
    for (int i = 0; i < fptd_pkg::NUM_OPS; i++) begin
      if (((i < fptd_pkg::FPOP1_OPS) ? is_fpop1 : is_fpop2) &&
          opf == fptd_pkg::OPF_CODE[i]) begin
        dec.hit  = 1'b1;
        dec.op   = fptd_pkg::OP_W'(i);
        dec.kind = fptd_pkg::OP_KIND[i];
      end
    end
  end

endmodule

// ----- hw/rtl/fptd_map.sv -----
`timescale 1ns / 1ps

module fptd_map (
  input  fptd_pkg::in_item_t  item,
  input  fptd_pkg::dec_t      dec,
  input  logic [2:0]          fprs,
  output fptd_pkg::out_item_t res,
  output logic [2:0]          fprs_nxt
);

  logic [1:0] p1, p2, pd;
  logic [4:0] f1, f2, fd;
  logic [5:0] i1, i2, id;
  logic       bad1, bad2, badd;
  logic [2:0] base;
  logic       half_hi;

  assign p1 = dec.kind[1:0];
  assign p2 = dec.kind[3:2];
  assign pd = dec.kind[5:4];
  assign f1 = item.insn_word[18:14];
  assign f2 = item.insn_word[4:0];
  assign fd = item.insn_word[29:25];

  // Single maps directly; double and quad fold bit 0 up to bit 5
  assign i1 = (p1 == fptd_pkg::PREC_S) ? {1'b0, f1} : {f1[0], f1[4:1], 1'b0};
  assign i2 = (p2 == fptd_pkg::PREC_S) ? {1'b0, f2} : {f2[0], f2[4:1], 1'b0};
  assign id = (pd == fptd_pkg::PREC_S) ? {1'b0, fd} : {fd[0], fd[4:1], 1'b0};

  assign bad1 = (p1 == fptd_pkg::PREC_Q) && f1[1];
  assign bad2 = (p2 == fptd_pkg::PREC_Q) && f2[1];
  assign badd = (pd == fptd_pkg::PREC_Q) && fd[1];

  assign half_hi = id[5];
  assign base    = fprs[fptd_pkg::FPRS_EN] ? fprs : fptd_pkg::FPRS_ENABLE_ONLY;

  always_comb begin
    res      = '0;
    fprs_nxt = fprs;
    res.new_trap_type = item.trap_type;
    if (!dec.hit) begin
      res.status = fptd_pkg::ST_NOT_OP;
    end else if (item.trap_type != dec.kind[11:8]) begin
      res.status  = fptd_pkg::ST_TT_MISMATCH;
      res.op_code = dec.op;
    end else if (bad1 || bad2 || badd) begin
      res.status        = fptd_pkg::ST_BAD_REG;
      res.op_code       = dec.op;
      res.new_trap_type = fptd_pkg::TT_BAD_REG;
    end else begin
      res.status        = fptd_pkg::ST_EMULATE;
      res.op_code       = dec.op;
      res.new_trap_type = fptd_pkg::TT_CLEAR;
      if (p1 != fptd_pkg::PREC_NONE) begin
        res.src1_index = i1;
        res.src1_zero  = !fprs[i1[5] ? fptd_pkg::FPRS_DU : fptd_pkg::FPRS_DL];
      end
      if (p2 != fptd_pkg::PREC_NONE) begin
        res.src2_index = i2;
        res.src2_zero  = !fprs[i2[5] ? fptd_pkg::FPRS_DU : fptd_pkg::FPRS_DL];
      end
      if (pd == fptd_pkg::PREC_NONE) begin
        res.dest_index  = {4'd0, fd[1:0]};
        res.dest_is_fcc = 1'b1;
      end else begin
        res.dest_index       = id;
        res.clear_gsr        = !fprs[fptd_pkg::FPRS_EN];
        res.clear_lower_half = !half_hi && !base[fptd_pkg::FPRS_DL];
        res.clear_upper_half = half_hi && !base[fptd_pkg::FPRS_DU];
        fprs_nxt             = base;
        fprs_nxt[half_hi ? fptd_pkg::FPRS_DU : fptd_pkg::FPRS_DL] = 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/fp_trap_instruction_decoder.sv -----
`timescale 1ns / 1ps

// Decoder for trapped FPOP1/FPOP2 instruction words. Each item carries the
// instruction word and the pending trap type; each yields exactly one result
// item with a status (emulate, not an emulated op, trap type mismatch or
// invalid register), the operation number, physical source and destination
// register indices with read-as-zero flags, half-clear and graphics-status
// clear requests, and the trap type to write back. The block holds the
// dirty-lower, dirty-upper and enable bits, cleared by reset, and updates
// them as each item passes from the input register to the result register.
// One item is accepted per cycle unless the result register stalls. An
// accepted item sits in the input register, goes through the decode plus
// the three-bit state update (the single logic stage) and lands in the
// result register, which raises out_valid. A stalled result register
// stalls the input register: in_ready falls only when both hold an item and
// out_ready is low, and it stays low during reset.

module fp_trap_instruction_decoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fptd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fptd_pkg::out_item_t out_data
);

  logic                s1_valid_r;
  fptd_pkg::in_item_t  s1_r;
  logic                out_valid_r;
  fptd_pkg::out_item_t out_r;
  logic [2:0]          fprs_r;
  logic [2:0]          fprs_nxt;
  fptd_pkg::dec_t      dec;
  fptd_pkg::out_item_t res;
  logic                adv;

  // Advance the staged item whenever the result register is free or draining
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = rst_n && (!s1_valid_r || adv);

  fptd_decode u_decode (
    .insn_word (s1_r.insn_word),
    .dec       (dec)
  );

  fptd_map u_map (
    .item     (s1_r),
    .dec      (dec),
    .fprs     (fprs_r),
    .res      (res),
    .fprs_nxt (fprs_nxt)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_r <= in_data;
    end
  end

  // Result register and state; state moves only with the item it belongs to
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      fprs_r      <= 3'b000;
    end else begin
      if (adv) begin
        out_valid_r <= 1'b1;
        fprs_r      <= fprs_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Enable bit, once set, is never dropped
  a_fef_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    fprs_r[fptd_pkg::FPRS_EN] |=> fprs_r[fptd_pkg::FPRS_EN])
    else $error("enable bit dropped");

  // State changes only when an item advances into the result register
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(fprs_r))
    else $error("state changed without an item");

  // Clear requests only come with an emulated register write
  a_clear_emul: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.clear_gsr || out_r.clear_lower_half ||
                    out_r.clear_upper_half)
    |-> out_r.status == fptd_pkg::ST_EMULATE && !out_r.dest_is_fcc)
    else $error("clear request on a non-writing result");

  // At most one half is cleared per result
  a_one_half: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.clear_lower_half && out_r.clear_upper_half))
    else $error("both halves cleared");

endmodule

// ----- sim/tb_fp_trap_instruction_decoder.sv -----
`timescale 1ns / 1ps

module tb_fp_trap_instruction_decoder;

  // Instruction format pieces used to assemble trapped words
  localparam logic [1:0] OP_ARITH  = 2'b10;
  localparam logic [5:0] OP3_FPOP1 = 6'h34;
  localparam logic [5:0] OP3_FPOP2 = 6'h35;

  // Opf of every emulated operation, in operation-number order
  localparam logic [8:0] OPF_TABLE [fptd_pkg::NUM_OPS] = '{
    9'h003, 9'h007, 9'h00b, 9'h02b, 9'h043, 9'h047, 9'h04b, 9'h04f, 9'h06e,
    9'h083, 9'h08c, 9'h0c7, 9'h0cb, 9'h0cc, 9'h0cd, 9'h0ce, 9'h0d3,
    9'h029, 9'h02a, 9'h041, 9'h042, 9'h045, 9'h046, 9'h049, 9'h04a, 9'h04d,
    9'h04e, 9'h069, 9'h081, 9'h082, 9'h0c6, 9'h0c9, 9'h0d1, 9'h0d2,
    9'h053, 9'h057
  };

  // Operand precisions (rs1 [1:0], rs2 [3:2], rd [5:4]) and trap type [11:8]
  localparam logic [11:0] KIND_TABLE [fptd_pkg::NUM_OPS] = '{
    12'h33c, 12'h33c, 12'h33c, 12'h33c, 12'h33f, 12'h33f, 12'h33f, 12'h33f,
    12'h33a, 12'h32c, 12'h338, 12'h31c, 12'h32c, 12'h334, 12'h334, 12'h338,
    12'h31c, 12'h214, 12'h228, 12'h215, 12'h22a, 12'h215, 12'h22a, 12'h215,
    12'h22a, 12'h215, 12'h22a, 12'h225, 12'h224, 12'h228, 12'h218, 12'h224,
    12'h214, 12'h218, 12'h30f, 12'h30f
  };

  localparam int PHASE_ITEMS = 120;
  localparam int MAX_PRINTS  = 40;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  fptd_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  fptd_pkg::out_item_t out_data;

  // Items waiting for the driver, and decodes waiting for the block's results
  fptd_pkg::in_item_t  pending_items[$];
  fptd_pkg::out_item_t expected_decodes[$];

  logic [2:0] fprs_model = '0;  // dirty lower, dirty upper, enable
  logic       in_taken = 1'b0;  // item accepted at the last rising edge
  int         in_idle_pct = 0;
  int         out_stall_pct = 0;
  int         error_count = 0;

  fp_trap_instruction_decoder DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Map a register field to its physical 32-bit index; low when a quad
  // register is misaligned.
  function automatic logic phys_reg(input logic [4:0] f, input logic [1:0] prec,
                                    output logic [5:0] idx);
    idx = (prec == fptd_pkg::PREC_S) ? {1'b0, f} : {f[0], f[4:1], 1'b0};
    return !(prec == fptd_pkg::PREC_Q && f[1]);
  endfunction

  // Decode one trapped instruction and advance the enable/dirty bits the way
  // the block must.
  function automatic fptd_pkg::out_item_t decode_trap(input fptd_pkg::in_item_t it);
    fptd_pkg::out_item_t r;
    logic [31:0] w;
    logic [11:0] kind;
    logic [5:0]  idx;
    logic        ok;
    logic        hi;
    int          op;
    r = '0;
    w = it.insn_word;
    op = -1;
    r.new_trap_type = it.trap_type;
    if ((w & fptd_pkg::OPC_MASK) == fptd_pkg::OPC_FPOP1) begin
      for (int i = 0; i < fptd_pkg::FPOP1_OPS; i++)
        if (OPF_TABLE[i] == w[13:5]) op = i;
    end else if ((w & fptd_pkg::OPC_MASK) == fptd_pkg::OPC_FPOP2) begin
      for (int i = fptd_pkg::FPOP1_OPS; i < fptd_pkg::NUM_OPS; i++)
        if (OPF_TABLE[i] == w[13:5]) op = i;
    end
    if (op < 0) begin
      r.status = fptd_pkg::ST_NOT_OP;
      return r;
    end
    r.op_code = op[fptd_pkg::OP_W-1:0];
    kind = KIND_TABLE[op];
    if (it.trap_type != kind[11:8]) begin
      r.status = fptd_pkg::ST_TT_MISMATCH;
      return r;
    end
    ok = 1'b1;
    // Check rs1, rs2, rd in order; zero flags read the state before the write
    if (kind[1:0] != fptd_pkg::PREC_NONE) begin
      ok = phys_reg(w[18:14], kind[1:0], idx);
      r.src1_index = idx;
      r.src1_zero = !fprs_model[idx[5] ? fptd_pkg::FPRS_DU : fptd_pkg::FPRS_DL];
    end
    if (ok && kind[3:2] != fptd_pkg::PREC_NONE) begin
      ok = phys_reg(w[4:0], kind[3:2], idx);
      r.src2_index = idx;
      r.src2_zero = !fprs_model[idx[5] ? fptd_pkg::FPRS_DU : fptd_pkg::FPRS_DL];
    end
    if (ok && kind[5:4] == fptd_pkg::PREC_NONE) begin
      r.dest_index = {4'b0, w[26:25]};
      r.dest_is_fcc = 1'b1;
    end else if (ok) begin
      ok = phys_reg(w[29:25], kind[5:4], idx);
      if (ok) begin
        r.dest_index = idx;
        hi = idx[5];
        // First write with the unit off: enable it, drop both dirty bits
        if (!fprs_model[fptd_pkg::FPRS_EN]) begin
          fprs_model = fptd_pkg::FPRS_ENABLE_ONLY;
          r.clear_gsr = 1'b1;
        end
        if (!fprs_model[hi ? fptd_pkg::FPRS_DU : fptd_pkg::FPRS_DL]) begin
          if (hi) r.clear_upper_half = 1'b1;
          else    r.clear_lower_half = 1'b1;
        end
        fprs_model[hi ? fptd_pkg::FPRS_DU : fptd_pkg::FPRS_DL] = 1'b1;
      end
    end
    if (!ok) begin
      r = '0;
      r.status = fptd_pkg::ST_BAD_REG;
      r.op_code = op[fptd_pkg::OP_W-1:0];
      r.new_trap_type = fptd_pkg::TT_BAD_REG;
      return r;
    end
    r.status = fptd_pkg::ST_EMULATE;
    r.new_trap_type = fptd_pkg::TT_CLEAR;
    return r;
  endfunction

  function automatic logic [31:0] build_insn(input int op, input logic [4:0] rd,
                                             input logic [4:0] rs1,
                                             input logic [4:0] rs2);
    return {OP_ARITH, rd, (op < fptd_pkg::FPOP1_OPS) ? OP3_FPOP1 : OP3_FPOP2, rs1,
            OPF_TABLE[op], rs2};
  endfunction

  // Random register field, mostly with bit 1 clear so quad operands pass
  function automatic logic [4:0] pick_reg();
    logic [4:0] f;
    f = 5'($urandom_range(31));
    if ($urandom_range(3) != 0) f[1] = 1'b0;
    return f;
  endfunction

  task automatic push_op(input int op, input logic [4:0] rd, input logic [4:0] rs1,
                         input logic [4:0] rs2, input logic [3:0] tt);
    pending_items.push_back(fptd_pkg::in_item_t'{insn_word: build_insn(op, rd, rs1, rs2),
                                                 trap_type: tt});
  endtask

  task automatic push_raw(input logic [31:0] w, input logic [3:0] tt);
    pending_items.push_back(fptd_pkg::in_item_t'{insn_word: w, trap_type: tt});
  endtask

  // Mostly well-formed instructions with the right trap type; the rest get a
  // random trap type, some also a random opf code in the FPOP class or noise.
  // The first NUM_OPS calls walk every operation once.
  task automatic push_random(input int seq);
    int          op;
    int          pick;
    logic [31:0] w;
    logic [3:0]  tt;
    pick = $urandom_range(99);
    op = (seq < fptd_pkg::NUM_OPS) ? seq : $urandom_range(fptd_pkg::NUM_OPS - 1);
    w = build_insn(op, pick_reg(), pick_reg(), pick_reg());
    tt = KIND_TABLE[op][11:8];
    if (seq >= fptd_pkg::NUM_OPS) begin
      if (pick >= 95) begin
        w = $urandom;
        tt = 4'($urandom_range(15));
      end else if (pick >= 85) begin
        w[13:5] = 9'($urandom_range(511));
        tt = 4'($urandom_range(15));
      end else if (pick >= 75) begin
        tt = 4'($urandom_range(15));
      end
    end
    push_raw(w, tt);
  endtask

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTS) $display("%0t ns: mismatch: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // Hold valid and payload until the item is taken, then advance to the
  // next pending item or idle at the phase's rate. Toggle out_ready too.
  always @(negedge clk) begin : item_driver
    logic               nxt_valid;
    fptd_pkg::in_item_t nxt_data;
    nxt_valid = in_valid;
    nxt_data = in_data;
    if (rst_n && (!in_valid || in_taken)) begin
      nxt_valid = 1'b0;
      if (pending_items.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
        nxt_data = pending_items.pop_front();
        nxt_valid = 1'b1;
      end
    end
    in_valid <= nxt_valid;
    in_data <= nxt_data;
    out_ready <= rst_n && ($urandom_range(99) >= out_stall_pct);
  end

  // Check each result against the oldest expected decode first, then predict
  // the item accepted at this edge; a result never leaves at the edge that
  // accepts its item, so the order is safe.
  always @(posedge clk) begin : result_monitor
    fptd_pkg::out_item_t want;
    in_taken <= in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_decodes.size() == 0) begin
          report_mismatch($sformatf("result %h with nothing expected", out_data));
        end else begin
          want = expected_decodes.pop_front();
          check_field("status", 32'(out_data.status), 32'(want.status));
          check_field("op_code", 32'(out_data.op_code), 32'(want.op_code));
          check_field("src1_index", 32'(out_data.src1_index), 32'(want.src1_index));
          check_field("src1_zero", 32'(out_data.src1_zero), 32'(want.src1_zero));
          check_field("src2_index", 32'(out_data.src2_index), 32'(want.src2_index));
          check_field("src2_zero", 32'(out_data.src2_zero), 32'(want.src2_zero));
          check_field("dest_index", 32'(out_data.dest_index), 32'(want.dest_index));
          check_field("dest_is_fcc", 32'(out_data.dest_is_fcc),
                      32'(want.dest_is_fcc));
          check_field("clear_lower_half", 32'(out_data.clear_lower_half),
                      32'(want.clear_lower_half));
          check_field("clear_upper_half", 32'(out_data.clear_upper_half),
                      32'(want.clear_upper_half));
          check_field("clear_gsr", 32'(out_data.clear_gsr), 32'(want.clear_gsr));
          check_field("new_trap_type", 32'(out_data.new_trap_type),
                      32'(want.new_trap_type));
        end
      end
      if (in_valid && in_ready) expected_decodes.push_back(decode_trap(in_data));
    end
  end

  // Wait at rising edges until every item went in and every result came out;
  // valid stays high through the accepting edge, so nothing slips past
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || expected_decodes.size() != 0);
    @(posedge clk);
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, class misses, mismatches, bad registers, first
    // writes with the unit off, both halves and both compares.
    push_raw(32'h0000_0000, 4'h0);
    push_raw(32'hffff_ffff, 4'hf);
    push_raw(fptd_pkg::OPC_FPOP1, 4'h3);                      // FPOP1, opf 0
    push_raw(fptd_pkg::OPC_FPOP2 | (32'h051 << 5), 4'h3);     // FPOP2 opf not emulated
    push_raw(fptd_pkg::OPC_FPOP1 | (32'h053 << 5), 4'h3);     // compare opf in FPOP1
    push_op(0, 5'd0, 5'd0, 5'd0, 4'h2);                // quad op, wrong trap type
    push_op(17, 5'd0, 5'd0, 5'd0, 4'h0);               // single op, wrong trap type
    push_op(0, 5'd0, 5'd0, 5'd0, 4'hf);
    push_op(4, 5'd0, 5'd2, 5'd0, 4'h3);                // misaligned quad rs1
    push_op(4, 5'd0, 5'd0, 5'd2, 4'h3);                // misaligned quad rs2
    push_op(4, 5'd2, 5'd0, 5'd0, 4'h3);                // misaligned quad rd
    push_op(4, 5'd31, 5'd31, 5'd0, 4'h3);              // rs1 and rd both bad
    push_op(34, 5'd3, 5'd0, 5'd29, 4'h3);              // compare, unit still off
    push_op(0, 5'd28, 5'd31, 5'd29, 4'h3);             // first write, rs1 unused
    push_op(19, 5'd31, 5'd0, 5'd31, 4'h2);             // single write, lower half
    push_op(20, 5'd1, 5'd1, 5'd0, 4'h2);               // double to upper half
    push_op(20, 5'd1, 5'd1, 5'd0, 4'h2);               // both halves now dirty
    push_op(20, 5'd31, 5'd31, 5'd30, 4'h2);
    push_op(35, 5'd2, 5'd29, 5'd29, 4'h3);
    push_op(8, 5'd29, 5'd31, 5'd30, 4'h3);
    push_op(27, 5'd31, 5'd31, 5'd31, 4'h2);
    push_op(16, 5'd0, 5'd0, 5'd0, 4'h3);

    // Phase 1: no idling on either side
    for (int i = 0; i < PHASE_ITEMS; i++) push_random(i);
    wait_drained();  // sender holds off here until every result is back

    // Phase 2: sender idles
    in_idle_pct = 45;
    for (int i = 0; i < PHASE_ITEMS; i++) push_random(i + fptd_pkg::NUM_OPS);
    wait_drained();

    // Phase 3: receiver stalls
    in_idle_pct = 0;
    out_stall_pct = 45;
    for (int i = 0; i < PHASE_ITEMS; i++) push_random(i + fptd_pkg::NUM_OPS);
    wait_drained();

    // Phase 4: both sides idle
    in_idle_pct = 35;
    out_stall_pct = 35;
    for (int i = 0; i < PHASE_ITEMS; i++) push_random(i + fptd_pkg::NUM_OPS);
    wait_drained();

    // Let any stray result show up before the verdict
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("fp_trap_instruction_decoder test passed");
    end else begin
      $display("fp_trap_instruction_decoder test failed");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("fp_trap_instruction_decoder test failed");
    $finish;
  end

endmodule
